// ===== rtl/ray_triangle_intersect_defines.svh =====
// ----------------------------------------------------------------------------
// Ray/triangle intersection: assertion macros
// Shared concurrent assertion forms for the checker, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection package
// Fixed widths and configuration register codes shared across the block.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int TAG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_AIM_X    = 3'd3,
    REG_AIM_Y    = 3'd4,
    REG_AIM_Z    = 3'd5
  } cfg_reg_e;

endpackage

// ===== rtl/rti_tri_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle input channel
// Valid/ready channel carrying one tagged triangle of three vertices.
// ----------------------------------------------------------------------------
interface rti_tri_if #(
  parameter int COORD_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [rti_pkg::TAG_W-1:0]     tri_tag;
  logic signed [COORD_BITS-1:0]  vertex_a_x;
  logic signed [COORD_BITS-1:0]  vertex_a_y;
  logic signed [COORD_BITS-1:0]  vertex_a_z;
  logic signed [COORD_BITS-1:0]  vertex_b_x;
  logic signed [COORD_BITS-1:0]  vertex_b_y;
  logic signed [COORD_BITS-1:0]  vertex_b_z;
  logic signed [COORD_BITS-1:0]  vertex_c_x;
  logic signed [COORD_BITS-1:0]  vertex_c_y;
  logic signed [COORD_BITS-1:0]  vertex_c_z;

  modport source (
    output valid, tri_tag,
    output vertex_a_x, vertex_a_y, vertex_a_z,
    output vertex_b_x, vertex_b_y, vertex_b_z,
    output vertex_c_x, vertex_c_y, vertex_c_z,
    input  ready
  );

  modport sink (
    input  valid, tri_tag,
    input  vertex_a_x, vertex_a_y, vertex_a_z,
    input  vertex_b_x, vertex_b_y, vertex_b_z,
    input  vertex_c_x, vertex_c_y, vertex_c_z,
    output ready
  );
endinterface

// ===== rtl/rti_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying the tag and hit flag of one triangle.
// ----------------------------------------------------------------------------
interface rti_res_if;
  logic                      valid;
  logic                      ready;
  logic [rti_pkg::TAG_W-1:0] tag_out;
  logic                      hit;

  modport source (output valid, tag_out, hit, input ready);
  modport sink   (input valid, tag_out, hit, output ready);
endinterface

// ===== rtl/rti_diff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge and offset stage
// Forms the ray direction, both triangle edges and the origin offset.
// ----------------------------------------------------------------------------
module rti_diff #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            vld_i,
  output logic                            rdy_o,
  output logic                            vld_o,
  input  logic                            rdy_i,
  input  logic [rti_pkg::TAG_W-1:0]       tag_i,
  input  logic signed [COORD_BITS-1:0]    org_i [3],
  input  logic signed [COORD_BITS-1:0]    aim_i [3],
  input  logic signed [COORD_BITS-1:0]    va_i  [3],
  input  logic signed [COORD_BITS-1:0]    vb_i  [3],
  input  logic signed [COORD_BITS-1:0]    vc_i  [3],
  output logic [rti_pkg::TAG_W-1:0]       tag_o,
  output logic signed [COORD_BITS:0]      dir_o [3],
  output logic signed [COORD_BITS:0]      e1_o  [3],
  output logic signed [COORD_BITS:0]      e2_o  [3],
  output logic signed [COORD_BITS:0]      s_o   [3]
);
  localparam int DW = COORD_BITS + 1;

  logic                  vld_q;
  logic [rti_pkg::TAG_W-1:0] tag_q;
  logic signed [DW-1:0]  dir_d [3], e1_d [3], e2_d [3], s_d [3];
  logic signed [DW-1:0]  dir_q [3], e1_q [3], e2_q [3], s_q [3];

  assign rdy_o = !vld_q || rdy_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dir_d[k] = DW'(aim_i[k]) - DW'(org_i[k]);
      e1_d[k]  = DW'(vb_i[k]) - DW'(va_i[k]);
      e2_d[k]  = DW'(vc_i[k]) - DW'(va_i[k]);
      s_d[k]   = DW'(org_i[k]) - DW'(va_i[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      tag_q <= tag_i;
      for (int k = 0; k < 3; k++) begin
        dir_q[k] <= dir_d[k];
        e1_q[k]  <= e1_d[k];
        e2_q[k]  <= e2_d[k];
        s_q[k]   <= s_d[k];
      end
    end
  end

  assign vld_o = vld_q;
  assign tag_o = tag_q;
  assign dir_o = dir_q;
  assign e1_o  = e1_q;
  assign e2_o  = e2_q;
  assign s_o   = s_q;
endmodule

// ===== rtl/rti_cross.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross product stage
// Forms h = dir x e2 and q = s x e1; passes the operands of the dot stage.
// ----------------------------------------------------------------------------
module rti_cross #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  output logic                             rdy_o,
  output logic                             vld_o,
  input  logic                             rdy_i,
  input  logic [rti_pkg::TAG_W-1:0]        tag_i,
  input  logic signed [COORD_BITS:0]       dir_i [3],
  input  logic signed [COORD_BITS:0]       e1_i  [3],
  input  logic signed [COORD_BITS:0]       e2_i  [3],
  input  logic signed [COORD_BITS:0]       s_i   [3],
  output logic [rti_pkg::TAG_W-1:0]        tag_o,
  output logic signed [COORD_BITS:0]       dir_o [3],
  output logic signed [COORD_BITS:0]       e1_o  [3],
  output logic signed [COORD_BITS:0]       e2_o  [3],
  output logic signed [COORD_BITS:0]       s_o   [3],
  output logic signed [2*COORD_BITS+2:0]   h_o   [3],
  output logic signed [2*COORD_BITS+2:0]   q_o   [3]
);
  localparam int DW = COORD_BITS + 1;
  localparam int MW = 2 * DW;
  localparam int PW = MW + 1;

  logic                      vld_q;
  logic [rti_pkg::TAG_W-1:0] tag_q;
  logic signed [MW-1:0]      hp [6], qp [6];
  logic signed [PW-1:0]      h_d [3], q_d [3], h_q [3], q_q [3];
  logic signed [DW-1:0]      dir_q [3], e1_q [3], e2_q [3], s_q [3];

  assign rdy_o = !vld_q || rdy_i;

  // Component products of the two cross products, minuend then subtrahend.
  always_comb begin
    hp[0] = dir_i[1] * e2_i[2];
    hp[1] = dir_i[2] * e2_i[1];
    hp[2] = dir_i[2] * e2_i[0];
    hp[3] = dir_i[0] * e2_i[2];
    hp[4] = dir_i[0] * e2_i[1];
    hp[5] = dir_i[1] * e2_i[0];
    qp[0] = s_i[1] * e1_i[2];
    qp[1] = s_i[2] * e1_i[1];
    qp[2] = s_i[2] * e1_i[0];
    qp[3] = s_i[0] * e1_i[2];
    qp[4] = s_i[0] * e1_i[1];
    qp[5] = s_i[1] * e1_i[0];
    for (int k = 0; k < 3; k++) begin
      h_d[k] = PW'(hp[2*k]) - PW'(hp[2*k+1]);
      q_d[k] = PW'(qp[2*k]) - PW'(qp[2*k+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      tag_q <= tag_i;
      for (int k = 0; k < 3; k++) begin
        h_q[k]   <= h_d[k];
        q_q[k]   <= q_d[k];
        dir_q[k] <= dir_i[k];
        e1_q[k]  <= e1_i[k];
        e2_q[k]  <= e2_i[k];
        s_q[k]   <= s_i[k];
      end
    end
  end

  assign vld_o = vld_q;
  assign tag_o = tag_q;
  assign dir_o = dir_q;
  assign e1_o  = e1_q;
  assign e2_o  = e2_q;
  assign s_o   = s_q;
  assign h_o   = h_q;
  assign q_o   = q_q;
endmodule

// ===== rtl/rti_dot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot product stages
// Registers the twelve term products, then sums them into det, un, vn, tn.
// ----------------------------------------------------------------------------
module rti_dot #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            vld_i,
  output logic                            rdy_o,
  output logic                            vld_o,
  input  logic                            rdy_i,
  input  logic [rti_pkg::TAG_W-1:0]       tag_i,
  input  logic signed [COORD_BITS:0]      dir_i [3],
  input  logic signed [COORD_BITS:0]      e1_i  [3],
  input  logic signed [COORD_BITS:0]      e2_i  [3],
  input  logic signed [COORD_BITS:0]      s_i   [3],
  input  logic signed [2*COORD_BITS+2:0]  h_i   [3],
  input  logic signed [2*COORD_BITS+2:0]  q_i   [3],
  output logic [rti_pkg::TAG_W-1:0]       tag_o,
  output logic signed [3*COORD_BITS+5:0]  det_o,
  output logic signed [3*COORD_BITS+5:0]  un_o,
  output logic signed [3*COORD_BITS+5:0]  vn_o,
  output logic signed [3*COORD_BITS+5:0]  tn_o
);
  localparam int MW = 3 * COORD_BITS + 4;
  localparam int SW = MW + 2;

  logic                      prd_vld_q, sum_vld_q, sum_rdy;
  logic [rti_pkg::TAG_W-1:0] prd_tag_q, sum_tag_q;
  logic signed [MW-1:0]      eh_d [3], sh_d [3], dq_d [3], eq_d [3];
  logic signed [MW-1:0]      eh_q [3], sh_q [3], dq_q [3], eq_q [3];
  logic signed [SW-1:0]      det_d, un_d, vn_d, tn_d;
  logic signed [SW-1:0]      det_q, un_q, vn_q, tn_q;

  assign sum_rdy = !sum_vld_q || rdy_i;
  assign rdy_o   = !prd_vld_q || sum_rdy;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      eh_d[k] = e1_i[k] * h_i[k];
      sh_d[k] = s_i[k] * h_i[k];
      dq_d[k] = dir_i[k] * q_i[k];
      eq_d[k] = e2_i[k] * q_i[k];
    end
    det_d = SW'(eh_q[0]) + SW'(eh_q[1]) + SW'(eh_q[2]);
    un_d  = SW'(sh_q[0]) + SW'(sh_q[1]) + SW'(sh_q[2]);
    vn_d  = SW'(dq_q[0]) + SW'(dq_q[1]) + SW'(dq_q[2]);
    tn_d  = SW'(eq_q[0]) + SW'(eq_q[1]) + SW'(eq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      if (rdy_o) begin
        prd_vld_q <= vld_i;
      end
      if (sum_rdy) begin
        sum_vld_q <= prd_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      prd_tag_q <= tag_i;
      for (int k = 0; k < 3; k++) begin
        eh_q[k] <= eh_d[k];
        sh_q[k] <= sh_d[k];
        dq_q[k] <= dq_d[k];
        eq_q[k] <= eq_d[k];
      end
    end
    if (sum_rdy && prd_vld_q) begin
      sum_tag_q <= prd_tag_q;
      det_q     <= det_d;
      un_q      <= un_d;
      vn_q      <= vn_d;
      tn_q      <= tn_d;
    end
  end

  assign vld_o = sum_vld_q;
  assign tag_o = sum_tag_q;
  assign det_o = det_q;
  assign un_o  = un_q;
  assign vn_o  = vn_q;
  assign tn_o  = tn_q;
endmodule

// ===== rtl/rti_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decision stage
// Applies the sign-aware barycentric and distance bounds; holds the result.
// ----------------------------------------------------------------------------
module rti_decide #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            vld_i,
  output logic                            rdy_o,
  output logic                            vld_o,
  input  logic                            rdy_i,
  input  logic [rti_pkg::TAG_W-1:0]       tag_i,
  input  logic signed [3*COORD_BITS+5:0]  det_i,
  input  logic signed [3*COORD_BITS+5:0]  un_i,
  input  logic signed [3*COORD_BITS+5:0]  vn_i,
  input  logic signed [3*COORD_BITS+5:0]  tn_i,
  output logic [rti_pkg::TAG_W-1:0]       tag_o,
  output logic                            hit_o
);
  localparam int SW = 3 * COORD_BITS + 6;

  logic                      vld_q, hit_q, hit_d;
  logic [rti_pkg::TAG_W-1:0] tag_q;
  logic signed [SW:0]        uv, det_x;
  logic                      un_le0, vn_le0, pos_ok, neg_ok;

  assign rdy_o = !vld_q || rdy_i;

  // A negative det flips every bound instead of negating the four sums.
  always_comb begin
    uv     = (SW + 1)'(un_i) + (SW + 1)'(vn_i);
    det_x  = (SW + 1)'(det_i);
    un_le0 = un_i[SW-1] || (un_i == '0);
    vn_le0 = vn_i[SW-1] || (vn_i == '0);
    pos_ok = !un_i[SW-1] && (un_i <= det_i) && !vn_i[SW-1] && (uv <= det_x)
             && !tn_i[SW-1] && (tn_i != '0);
    neg_ok = un_le0 && (un_i >= det_i) && vn_le0 && (uv >= det_x) && tn_i[SW-1];
    hit_d  = (det_i != '0) && (det_i[SW-1] ? neg_ok : pos_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      tag_q <= tag_i;
      hit_q <= hit_d;
    end
  end

  assign vld_o = vld_q;
  assign tag_o = tag_q;
  assign hit_o = hit_q;
endmodule

// ===== rtl/ray_triangle_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection
// Exact integer Moller-Trumbore hit test of a streamed triangle against
// one configured ray, in a five-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                  Transfer
//   -------   ---   --------------------------------------   ------------------
//   tri_i     in    tri_tag, vertex_{a,b,c}_{x,y,z}          valid && ready
//   res_o     out   tag_out, hit                             valid && ready
//   cfg       in    cfg_idx_i, cfg_data_i                    cfg_we_i
//
// One triangle is taken per cycle while the first stage has room; the transfer
// edge loads the first of five register stages, and the item passes through
// them in order (edges, cross products, dot-product terms, sums, decision).
// Each stage holds its item while the next one is full and cannot pass on, so
// a stall on res_o backs up stage by stage and empty stages keep filling;
// nothing is lost. Reset clears all stage valid bits and sets the ray
// registers to zero. Change the ray only while the pipeline is empty.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rti_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [COORD_BITS-1:0]              cfg_data_i,
  rti_tri_if.sink                            tri_i,
  rti_res_if.source                          res_o
);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 3;
  localparam int SW = 3 * COORD_BITS + 6;

  // Ray registers: origin and aim point.
  logic signed [COORD_BITS-1:0] org_q [3];
  logic signed [COORD_BITS-1:0] aim_q [3];

  logic signed [COORD_BITS-1:0] va [3], vb [3], vc [3];

  // Stage interconnect.
  logic                      d_vld, d_rdy, c_vld, c_rdy, p_vld, p_rdy, o_rdy;
  logic [rti_pkg::TAG_W-1:0] d_tag, c_tag, p_tag;
  logic signed [DW-1:0]      d_dir [3], d_e1 [3], d_e2 [3], d_s [3];
  logic signed [DW-1:0]      c_dir [3], c_e1 [3], c_e2 [3], c_s [3];
  logic signed [PW-1:0]      c_h [3], c_q [3];
  logic signed [SW-1:0]      p_det, p_un, p_vn, p_tn;

  // Take register writes; drop writes to indexes past the last register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        org_q[k] <= '0;
        aim_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (rti_pkg::cfg_reg_e'(cfg_idx_i))
        rti_pkg::REG_ORIGIN_X: org_q[0] <= cfg_data_i;
        rti_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        rti_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        rti_pkg::REG_AIM_X:    aim_q[0] <= cfg_data_i;
        rti_pkg::REG_AIM_Y:    aim_q[1] <= cfg_data_i;
        rti_pkg::REG_AIM_Z:    aim_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Gather the vertex fields into per-axis arrays.
  assign va[0] = tri_i.vertex_a_x;
  assign va[1] = tri_i.vertex_a_y;
  assign va[2] = tri_i.vertex_a_z;
  assign vb[0] = tri_i.vertex_b_x;
  assign vb[1] = tri_i.vertex_b_y;
  assign vb[2] = tri_i.vertex_b_z;
  assign vc[0] = tri_i.vertex_c_x;
  assign vc[1] = tri_i.vertex_c_y;
  assign vc[2] = tri_i.vertex_c_z;

  // Stage 1: direction, edges and origin offset.
  rti_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (tri_i.valid),
    .rdy_o  (tri_i.ready),
    .vld_o  (d_vld),
    .rdy_i  (d_rdy),
    .tag_i  (tri_i.tri_tag),
    .org_i  (org_q),
    .aim_i  (aim_q),
    .va_i   (va),
    .vb_i   (vb),
    .vc_i   (vc),
    .tag_o  (d_tag),
    .dir_o  (d_dir),
    .e1_o   (d_e1),
    .e2_o   (d_e2),
    .s_o    (d_s)
  );

  // Stage 2: cross products h and q.
  rti_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (d_vld),
    .rdy_o  (d_rdy),
    .vld_o  (c_vld),
    .rdy_i  (c_rdy),
    .tag_i  (d_tag),
    .dir_i  (d_dir),
    .e1_i   (d_e1),
    .e2_i   (d_e2),
    .s_i    (d_s),
    .tag_o  (c_tag),
    .dir_o  (c_dir),
    .e1_o   (c_e1),
    .e2_o   (c_e2),
    .s_o    (c_s),
    .h_o    (c_h),
    .q_o    (c_q)
  );

  // Stages 3 and 4: dot-product terms, then their sums.
  rti_dot #(.COORD_BITS(COORD_BITS)) u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (c_vld),
    .rdy_o  (c_rdy),
    .vld_o  (p_vld),
    .rdy_i  (p_rdy),
    .tag_i  (c_tag),
    .dir_i  (c_dir),
    .e1_i   (c_e1),
    .e2_i   (c_e2),
    .s_i    (c_s),
    .h_i    (c_h),
    .q_i    (c_q),
    .tag_o  (p_tag),
    .det_o  (p_det),
    .un_o   (p_un),
    .vn_o   (p_vn),
    .tn_o   (p_tn)
  );

  // Stage 5: bounds test into the output register.
  rti_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (p_vld),
    .rdy_o  (p_rdy),
    .vld_o  (res_o.valid),
    .rdy_i  (o_rdy),
    .tag_i  (p_tag),
    .det_i  (p_det),
    .un_i   (p_un),
    .vn_i   (p_vn),
    .tn_i   (p_tn),
    .tag_o  (res_o.tag_out),
    .hit_o  (res_o.hit)
  );

  assign o_rdy = res_o.ready;
endmodule

// ===== rtl/rti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection port checker
// Watches the top-level channels for stall, backpressure and reset behavior.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_defines.svh"

module rti_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rti_pkg::TAG_W-1:0] tag_out_i,
  input logic                      hit_i
);
  logic                    out_stall;
  logic [rti_pkg::TAG_W:0] res_bits;

  assign out_stall = out_valid_i && !out_ready_i;
  assign res_bits  = {tag_out_i, hit_i};

  // A result held back by the sink stays put.
  `RTI_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(res_bits), "held result changed")

  // Input backpressure only when every stage is full and the output is stalled.
  `RTI_ASSERT_SAME(a_ready_low, !in_ready_i, out_stall, "input stalled with room in pipeline")

  // No result straight out of reset.
  `RTI_ASSERT_SAME(a_reset_empty, $past(!rst_ni), !out_valid_i, "result valid right after reset")

  // An offered result carries known tag and hit bits.
  `RTI_ASSERT_SAME(a_out_known, out_valid_i, !$isunknown(res_bits), "result payload unknown")
endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (tri_i.valid),
  .in_ready_i  (tri_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .tag_out_i   (res_o.tag_out),
  .hit_i       (res_o.hit)
);

// ===== verif/ray_triangle_intersect_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection testbench
// Streams tagged triangles through the hit-test pipeline against a series of
// configured rays. A scoreboard predicts each hit flag with exact 64-bit
// integer arithmetic and checks every result against it, in order. Both
// channel sides idle at random.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_test;

  localparam int     COORD_BITS   = 16;
  localparam longint COORD_MAX    = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN    = -(longint'(1) << (COORD_BITS - 1));
  localparam int     MAX_GAP      = 18;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     TOTAL_ITEMS  = 1150;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     MAX_REPORTS  = 10;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [rti_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rti_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [rti_pkg::TAG_W-1:0] tag;
    coord_t                    ax, ay, az;
    coord_t                    bx, by, bz;
    coord_t                    cx, cy, cz;
  } triangle_t;

  typedef struct packed {
    logic [rti_pkg::TAG_W-1:0] tag;
    logic                      hit;
  } verdict_t;

  // Sign-extend a coordinate to full 64-bit precision.
  function automatic longint wide(coord_t c);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the ray, exact hit prediction, in-order check
  // --------------------------------------------------------------------------
  class hit_scoreboard;
    coord_t   org_x, org_y, org_z;
    coord_t   aim_x, aim_y, aim_z;
    verdict_t awaiting[$];
    int       mismatches;
    int       hit_count;
    int       miss_count;
    int       flat_count;

    function new();
      org_x = '0; org_y = '0; org_z = '0;
      aim_x = '0; aim_y = '0; aim_z = '0;
      mismatches = 0;
      hit_count  = 0;
      miss_count = 0;
      flat_count = 0;
    endfunction

    function void set_reg(logic [rti_pkg::CFG_IDX_W-1:0] idx, coord_t data);
      case (idx)
        rti_pkg::REG_ORIGIN_X: org_x = data;
        rti_pkg::REG_ORIGIN_Y: org_y = data;
        rti_pkg::REG_ORIGIN_Z: org_z = data;
        rti_pkg::REG_AIM_X:    aim_x = data;
        rti_pkg::REG_AIM_Y:    aim_y = data;
        rti_pkg::REG_AIM_Z:    aim_z = data;
        default: ;
      endcase
    endfunction

    // Barycentrics and distance stay scaled by the determinant.
    function bit intersects(triangle_t t);
      longint dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z;
      longint hx, hy, hz, sx, sy, sz, qx, qy, qz;
      longint det, un, vn, tn;
      dx  = wide(aim_x) - wide(org_x);
      dy  = wide(aim_y) - wide(org_y);
      dz  = wide(aim_z) - wide(org_z);
      e1x = wide(t.bx) - wide(t.ax);
      e1y = wide(t.by) - wide(t.ay);
      e1z = wide(t.bz) - wide(t.az);
      e2x = wide(t.cx) - wide(t.ax);
      e2y = wide(t.cy) - wide(t.ay);
      e2z = wide(t.cz) - wide(t.az);
      hx  = dy * e2z - dz * e2y;
      hy  = dz * e2x - dx * e2z;
      hz  = dx * e2y - dy * e2x;
      det = e1x * hx + e1y * hy + e1z * hz;
      if (det == 0) begin
        flat_count++;
        return 1'b0;
      end
      sx  = wide(org_x) - wide(t.ax);
      sy  = wide(org_y) - wide(t.ay);
      sz  = wide(org_z) - wide(t.az);
      qx  = sy * e1z - sz * e1y;
      qy  = sz * e1x - sx * e1z;
      qz  = sx * e1y - sy * e1x;
      un  = sx * hx + sy * hy + sz * hz;
      vn  = dx * qx + dy * qy + dz * qz;
      tn  = e2x * qx + e2y * qy + e2z * qz;
      // Flip signs so the determinant is positive.
      if (det < 0) begin
        det = -det;
        un  = -un;
        vn  = -vn;
        tn  = -tn;
      end
      return (un >= 0) && (un <= det) && (vn >= 0) && (un + vn <= det) && (tn > 0);
    endfunction

    function void note_triangle(triangle_t t);
      verdict_t v;
      v.tag = t.tag;
      v.hit = intersects(t);
      if (v.hit) hit_count++;
      else miss_count++;
      awaiting.push_back(v);
    endfunction

    function void check_result(logic [rti_pkg::TAG_W-1:0] tag, logic hit);
      verdict_t want;
      if (awaiting.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result tag %h hit %b with no triangle outstanding", tag, hit);
      end else begin
        want = awaiting.pop_front();
        if (tag !== want.tag || hit !== want.hit) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: tag expected %h got %h, hit expected %b got %b",
                     want.tag, tag, want.hit, hit);
        end
      end
    endfunction

    function int pending();
      return awaiting.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [rti_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [COORD_BITS-1:0]         cfg_data;

  rti_tri_if #(.COORD_BITS(COORD_BITS)) tri_bus ();
  rti_res_if                            res_bus ();

  ray_triangle_intersect #(
    .COORD_BITS (COORD_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .tri_i      (tri_bus),
    .res_o      (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  hit_scoreboard sb;
  longint        ray_org [3];   // current ray, for shaping the stimulus
  longint        ray_aim [3];
  int            total_sent;
  int            phase_count;
  int            cycle_count;
  bit            src_calm;
  bit            snk_calm;

  // Watchdog: end the run if it stalls far beyond any correct run.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited",
               cycle_count, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic coord_t clip(longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic longint jitter(int r);
    return longint'($urandom_range(0, 2 * r)) - longint'(r);
  endfunction

  function automatic longint extreme_coord();
    case ($urandom_range(0, 4))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic triangle_t mk(input logic [rti_pkg::TAG_W-1:0] tag,
                                   input longint ax, ay, az, bx, by, bz, cx, cy, cz);
    triangle_t t;
    t.tag = tag;
    t.ax = clip(ax); t.ay = clip(ay); t.az = clip(az);
    t.bx = clip(bx); t.by = clip(by); t.bz = clip(bz);
    t.cx = clip(cx); t.cy = clip(cy); t.cz = clip(cz);
    return t;
  endfunction

  // Most triangles sit around the aim point, which lies ahead on the ray, so
  // a good share of them hit; the rest are behind, parallel, flat or noise.
  function automatic triangle_t make_triangle();
    longint p [3];
    longint a [3];
    longint b [3];
    longint c [3];
    longint w [3];
    int     kind;
    int     radius;
    int     m;
    int     n;
    radius = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 6000) : $urandom_range(1, 400);
    kind   = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) p[i] = ray_aim[i];
    if (kind < 60) begin
      if (kind >= 50)
        for (int i = 0; i < 3; i++) p[i] = 2 * ray_org[i] - ray_aim[i];
      for (int i = 0; i < 3; i++) begin
        a[i] = p[i] + jitter(radius);
        b[i] = p[i] + jitter(radius);
        c[i] = p[i] + jitter(radius);
      end
    end else if (kind < 68) begin
      // vertex exactly on the ray
      for (int i = 0; i < 3; i++) begin
        a[i] = p[i];
        b[i] = p[i] + jitter(radius);
        c[i] = p[i] + jitter(radius);
      end
    end else if (kind < 76) begin
      // edge midpoint exactly on the ray
      for (int i = 0; i < 3; i++) begin
        w[i] = jitter(radius);
        a[i] = p[i] - w[i];
        b[i] = p[i] + w[i];
        c[i] = p[i] + jitter(radius);
      end
    end else if (kind < 84) begin
      // plane contains the direction, or the triangle collapses
      m = $urandom_range(0, 2);
      n = $urandom_range(0, 2) - 1;
      for (int i = 0; i < 3; i++) begin
        w[i] = jitter(radius);
        a[i] = p[i] + jitter(radius);
        b[i] = a[i] + w[i];
        c[i] = a[i] + m * w[i] + n * (ray_aim[i] - ray_org[i]);
      end
    end else if (kind < 92) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = wide(coord_t'($urandom));
        b[i] = wide(coord_t'($urandom));
        c[i] = wide(coord_t'($urandom));
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        a[i] = extreme_coord();
        b[i] = extreme_coord();
        c[i] = extreme_coord();
      end
    end
    return mk(rti_pkg::TAG_W'($urandom), a[0], a[1], a[2], b[0], b[1], b[2],
              c[0], c[1], c[2]);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_triangle(input triangle_t t);
    int gap;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk_i);
      tri_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    tri_bus.valid      = 1'b1;
    tri_bus.tri_tag    = t.tag;
    tri_bus.vertex_a_x = t.ax;
    tri_bus.vertex_a_y = t.ay;
    tri_bus.vertex_a_z = t.az;
    tri_bus.vertex_b_x = t.bx;
    tri_bus.vertex_b_y = t.by;
    tri_bus.vertex_b_z = t.bz;
    tri_bus.vertex_c_x = t.cx;
    tri_bus.vertex_c_y = t.cy;
    tri_bus.vertex_c_z = t.cz;
    // hold until the transfer
    do @(posedge clk_i); while (tri_bus.ready !== 1'b1);
    sb.note_triangle(t);
    total_sent++;
  endtask

  // Drop valid, then wait until every result is back and the pipe is quiet.
  task automatic drain();
    @(negedge clk_i);
    tri_bus.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // The enable stays high across back-to-back writes; load_ray drops it.
  task automatic write_reg(input logic [rti_pkg::CFG_IDX_W-1:0] idx, input coord_t data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic load_ray(input longint ox, oy, oz, ax, ay, az);
    ray_org[0] = wide(clip(ox));
    ray_org[1] = wide(clip(oy));
    ray_org[2] = wide(clip(oz));
    ray_aim[0] = wide(clip(ax));
    ray_aim[1] = wide(clip(ay));
    ray_aim[2] = wide(clip(az));
    // a stray write past the register list must be ignored
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, coord_t'($urandom));
    write_reg(rti_pkg::REG_ORIGIN_X, clip(ox));
    write_reg(rti_pkg::REG_ORIGIN_Y, clip(oy));
    write_reg(rti_pkg::REG_ORIGIN_Z, clip(oz));
    write_reg(rti_pkg::REG_AIM_X, clip(ax));
    write_reg(rti_pkg::REG_AIM_Y, clip(ay));
    write_reg(rti_pkg::REG_AIM_Z, clip(az));
    @(negedge clk_i);
    cfg_we = 1'b0;
    phase_count++;
  endtask

  task automatic random_ray();
    longint o [3];
    longint a [3];
    int     kind;
    int     r;
    kind = $urandom_range(0, 9);
    r    = $urandom_range(1, 4000);
    for (int i = 0; i < 3; i++) begin
      if (kind < 6) begin
        o[i] = jitter(4000);
        a[i] = o[i] + jitter(r);
      end else if (kind < 9) begin
        o[i] = wide(coord_t'($urandom));
        a[i] = wide(coord_t'($urandom));
      end else begin
        o[i] = wide(coord_t'($urandom));
        a[i] = o[i];
      end
    end
    load_ray(o[0], o[1], o[2], a[0], a[1], a[2]);
  endtask

  task automatic random_phase(input int count);
    repeat (count) send_triangle(make_triangle());
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, check every transfer
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    res_bus.ready = 1'b0;
    snk_calm      = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
      stall = snk_calm ? 0 : $urandom_range(0, MAX_GAP);
      repeat (stall) begin
        @(negedge clk_i);
        res_bus.ready = 1'b0;
      end
      @(negedge clk_i);
      res_bus.ready = 1'b1;
      do @(posedge clk_i); while (res_bus.valid !== 1'b1);
      sb.check_result(res_bus.tag_out, res_bus.hit);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb          = new();
    total_sent  = 0;
    phase_count = 1;
    src_calm    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = 0;
      ray_aim[i] = 0;
    end
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = rti_pkg::REG_ORIGIN_X;
    cfg_data           = '0;
    tri_bus.valid      = 1'b0;
    tri_bus.tri_tag    = '0;
    tri_bus.vertex_a_x = '0;
    tri_bus.vertex_a_y = '0;
    tri_bus.vertex_a_z = '0;
    tri_bus.vertex_b_x = '0;
    tri_bus.vertex_b_y = '0;
    tri_bus.vertex_b_z = '0;
    tri_bus.vertex_c_x = '0;
    tri_bus.vertex_c_y = '0;
    tri_bus.vertex_c_z = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset ray: origin equals aim, so the direction is zero and all miss.
    send_triangle(mk(16'h0001, -256, -256, 512, 512, -256, 512, -256, 512, 512));
    send_triangle(mk(16'h0002, -256, -256, 0, 512, -256, 0, -256, 512, 0));
    send_triangle(make_triangle());
    drain();

    // Ray from the origin along +z.
    load_ray(0, 0, 0, 0, 0, 256);
    // interior hit, then the same with reversed winding (negative det)
    send_triangle(mk(16'h0010, -256, -256, 512, 512, -256, 512, -256, 512, 512));
    send_triangle(mk(16'h0011, -256, -256, 512, -256, 512, 512, 512, -256, 512));
    // ray through a vertex, then through an edge: inclusive bounds
    send_triangle(mk(16'h0012, 0, 0, 768, 256, 0, 768, 0, 256, 768));
    send_triangle(mk(16'h0013, -256, 0, 512, 256, 0, 512, 0, 256, 512));
    // one step outside that edge
    send_triangle(mk(16'h0014, -256, 1, 512, 256, 1, 512, 0, 256, 512));
    // clear miss beside the ray
    send_triangle(mk(16'h0015, 256, 256, 512, 512, 256, 512, 256, 512, 512));
    // behind the origin
    send_triangle(mk(16'h0016, -256, -256, -512, 512, -256, -512, -256, 512, -512));
    // crossing exactly at the origin: distance zero is a miss
    send_triangle(mk(16'h0017, -256, -256, 0, 512, -256, 0, -256, 512, 0));
    // plane parallel to the ray
    send_triangle(mk(16'h0018, -256, 0, 256, 256, 0, 256, 0, 0, 512));
    // all three vertices equal, then three collinear vertices
    send_triangle(mk(16'h0019, 100, 100, 100, 100, 100, 100, 100, 100, 100));
    send_triangle(mk(16'h001a, 0, 0, 512, 256, 0, 512, 512, 0, 512));
    // extreme coordinates and tags
    send_triangle(mk(16'h0000, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                     COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_triangle(mk(16'hffff, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                     COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_triangle(mk(16'h5a5a, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                     COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
    send_triangle(mk(16'ha5a5, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                     COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
    send_triangle(mk(16'h7fff, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                     COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    drain();

    // Longest diagonal ray, both directions.
    load_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    send_triangle(mk(16'h8000, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                     COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX));
    random_phase(60);
    drain();
    load_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
    random_phase(60);
    drain();

    // Nonzero origin equal to aim.
    load_ray(1234, -4321, 77, 1234, -4321, 77);
    random_phase(30);

    // Random rays, each with its own batch of triangles.
    while (total_sent < TOTAL_ITEMS) begin
      drain();
      random_ray();
      random_phase($urandom_range(60, 140));
    end
    drain();

    $display("Sent %0d triangles over %0d ray settings: %0d predicted hits, %0d misses",
             total_sent, phase_count, sb.hit_count, sb.miss_count);
    $display("  (%0d with zero determinant); %0d result mismatches",
             sb.flat_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
